@@ src/smcv_pkg.sv @@
// Package: item types, command and register codes, and default sizes for the vote unit.
package smcv_pkg;

  localparam int SEGMENTS_DEF   = 1024;
  localparam int CLASSES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 24;

  localparam int SEG_ID_W   = 10;
  localparam int CLASS_ID_W = 4;
  localparam int CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LABEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_SEG_ND_EN  = 2'd0;
  localparam logic [1:0] REG_SEG_ND_VAL = 2'd1;
  localparam logic [1:0] REG_CLS_ND_EN  = 2'd2;
  localparam logic [1:0] REG_CLS_ND_VAL = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [SEG_ID_W-1:0]   segment_id;
    logic [CLASS_ID_W-1:0] class_id;
  } in_t;

  typedef struct packed {
    logic [CLASS_ID_W-1:0] majority_class;
    logic                  no_data;
  } out_t;

endpackage

@@ src/segment_majority_class_vote_unit.sv @@
// Top level: per-segment class vote counters with running best class, held in block memories.
//
//  channel | dir | handshake                      | payload
//  --------+-----+--------------------------------+-------------------------------------
//  in      | in  | in_valid_i / in_stall_o        | in_data_i  (cmd, segment_id, class_id)
//  out     | out | out_valid_o / out_stall_i      | out_data_o (majority_class, no_data)
//  cfg     | in  | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// Accumulate and label items are taken one per cycle while in_stall_o is low: read at acceptance, modify and
// write back on the next cycle, with the last write forwarded to the next item.
// A label result is loaded into the output register from stage 1 once that register is empty or not stalled.
// Clear, and reset, sweep the counter memory one entry a cycle over all SEGMENTS << clog2(CLASSES) entries
// (16384 at the defaults), zeroing the best-class memory alongside; in_stall_o stays high meanwhile.
// A label blocked behind a stalled full output register stalls the input.
module segment_majority_class_vote_unit
  import smcv_pkg::*;
#(
  parameter int SEGMENTS   = SEGMENTS_DEF,
  parameter int CLASSES    = CLASSES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int CLS_W      = $clog2(CLASSES);
  localparam int PA_W       = SEG_W + CLS_W;
  localparam int PAIR_DEPTH = SEGMENTS * (2 ** CLS_W);
  localparam int BEST_W     = COUNT_BITS + CLS_W;
  localparam int SEG_XW     = (SEG_W > SEG_ID_W) ? SEG_W : SEG_ID_W;
  localparam int CLS_XW     = (CLS_W > CLASS_ID_W) ? CLS_W : CLASS_ID_W;
  localparam logic [PA_W-1:0] CLR_LAST = PA_W'(PAIR_DEPTH - 1);

  // configuration
  logic                  seg_nd_en_q;
  logic [SEG_ID_W-1:0]   seg_nd_val_q;
  logic                  cls_nd_en_q;
  logic [CLASS_ID_W-1:0] cls_nd_val_q;
  logic                  cfg_we;
  logic [1:0]            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_nd_en_q  <= 1'b0;
      seg_nd_val_q <= '0;
      cls_nd_en_q  <= 1'b0;
      cls_nd_val_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SEG_ND_EN:  seg_nd_en_q  <= pwdata[0];
        REG_SEG_ND_VAL: seg_nd_val_q <= pwdata[SEG_ID_W-1:0];
        REG_CLS_ND_EN:  cls_nd_en_q  <= pwdata[0];
        REG_CLS_ND_VAL: cls_nd_val_q <= pwdata[CLASS_ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SEG_ND_EN:  prdata = DATA_W'(seg_nd_en_q);
      REG_SEG_ND_VAL: prdata = DATA_W'(seg_nd_val_q);
      REG_CLS_ND_EN:  prdata = DATA_W'(cls_nd_en_q);
      REG_CLS_ND_VAL: prdata = DATA_W'(cls_nd_val_q);
      default:        prdata = '0;
    endcase
  end

  // input side address
  logic [SEG_XW-1:0] rd_seg_x;
  logic [CLS_XW-1:0] rd_cls_x;
  logic [SEG_W-1:0]  rd_seg;
  logic [PA_W-1:0]   rd_pa;
  logic              in_acc;

  assign rd_seg_x = SEG_XW'(in_data_i.segment_id);
  assign rd_cls_x = CLS_XW'(in_data_i.class_id);
  assign rd_seg   = rd_seg_x[SEG_W-1:0];
  assign rd_pa    = {rd_seg, rd_cls_x[CLS_W-1:0]};

  // memories
  logic [COUNT_BITS-1:0] pair_mem [PAIR_DEPTH];
  logic [BEST_W-1:0]     best_mem [SEGMENTS];
  logic [COUNT_BITS-1:0] pair_rd_q;
  logic [BEST_W-1:0]     best_rd_q;
  logic                  pair_we;
  logic [PA_W-1:0]       pair_wa;
  logic [COUNT_BITS-1:0] pair_wd;
  logic                  best_we_m;
  logic [SEG_W-1:0]      best_wa;
  logic [BEST_W-1:0]     best_wd;

  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[pair_wa] <= pair_wd;
    if (in_acc)  pair_rd_q <= pair_mem[rd_pa];
  end

  always_ff @(posedge clk_i) begin
    if (best_we_m) best_mem[best_wa] <= best_wd;
    if (in_acc)    best_rd_q <= best_mem[rd_seg];
  end

  // stage 1
  logic             s1_valid_q;
  in_t              s1_q;
  logic [PA_W-1:0]  s1_pa_q;
  logic [SEG_W-1:0] s1_seg_q;

  // write-back forwarding
  logic                  wb_pair_v_q;
  logic [PA_W-1:0]       wb_pa_q;
  logic [COUNT_BITS-1:0] wb_cnt_q;
  logic                  wb_best_v_q;
  logic [SEG_W-1:0]      wb_seg_q;
  logic [BEST_W-1:0]     wb_best_q;

  // clearing sweep
  logic            clr_q;
  logic [PA_W-1:0] clr_cnt_q;

  logic                  out_valid_q;
  out_t                  out_q;

  logic                  seg_nd, cls_nd, seg_ok, cls_ok;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_new;
  logic [BEST_W-1:0]     best_cur;
  logic [COUNT_BITS-1:0] best_cnt_cur;
  logic [CLS_W-1:0]      best_cls_cur;
  logic [CLS_XW-1:0]     best_cls_x;
  logic [CLS_XW-1:0]     s1_cls_x;
  logic                  best_upd, acc_we, best_we, lab, lab_nd, s1_adv, out_load, clr_start;

  always_comb begin
    s1_cls_x     = CLS_XW'(s1_q.class_id);
    seg_nd       = seg_nd_en_q && (s1_q.segment_id == seg_nd_val_q);
    cls_nd       = cls_nd_en_q && (s1_q.class_id == cls_nd_val_q);
    seg_ok       = 32'(s1_q.segment_id) < 32'(SEGMENTS);
    cls_ok       = 32'(s1_q.class_id) < 32'(CLASSES);
    cnt_cur      = (wb_pair_v_q && (wb_pa_q == s1_pa_q)) ? wb_cnt_q : pair_rd_q;
    best_cur     = (wb_best_v_q && (wb_seg_q == s1_seg_q)) ? wb_best_q : best_rd_q;
    best_cnt_cur = best_cur[BEST_W-1:CLS_W];
    best_cls_cur = best_cur[CLS_W-1:0];
    best_cls_x   = CLS_XW'(best_cls_cur);
    cnt_new      = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;
    best_upd     = (cnt_new > best_cnt_cur) ||
                   ((cnt_new == best_cnt_cur) && (s1_cls_x[CLS_W-1:0] < best_cls_cur));
    acc_we       = s1_valid_q && (s1_q.cmd == CMD_ACC) && !seg_nd && !cls_nd && seg_ok && cls_ok;
    best_we      = acc_we && best_upd;
    lab          = s1_valid_q && (s1_q.cmd == CMD_LABEL);
    lab_nd       = seg_nd || !seg_ok || (best_cnt_cur == '0);
    clr_start    = s1_valid_q && (s1_q.cmd == CMD_CLEAR);
    out_load     = lab && (!out_valid_q || !out_stall_i);
    s1_adv       = !(lab && out_valid_q && out_stall_i);
    in_stall_o   = clr_q || (s1_valid_q && ((s1_q.cmd == CMD_CLEAR) || !s1_adv));
    in_acc       = in_valid_i && !in_stall_o;

    pair_we   = clr_q || acc_we;
    pair_wa   = clr_q ? clr_cnt_q : s1_pa_q;
    pair_wd   = clr_q ? '0 : cnt_new;
    best_we_m = clr_q || best_we;
    best_wa   = clr_q ? clr_cnt_q[PA_W-1:CLS_W] : s1_seg_q;
    best_wd   = clr_q ? '0 : {cnt_new, s1_cls_x[CLS_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      wb_pair_v_q <= 1'b0;
      wb_best_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (clr_start) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
      end else if (clr_q) begin
        if (clr_cnt_q == CLR_LAST) begin
          clr_q     <= 1'b0;
          clr_cnt_q <= '0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end

      if (clr_start || clr_q) begin
        wb_pair_v_q <= 1'b0;
        wb_best_v_q <= 1'b0;
      end else if (acc_we) begin
        wb_pair_v_q <= 1'b1;
        wb_best_v_q <= best_we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q     <= in_data_i;
      s1_pa_q  <= rd_pa;
      s1_seg_q <= rd_seg;
    end
    if (acc_we) begin
      wb_pa_q   <= s1_pa_q;
      wb_cnt_q  <= cnt_new;
      wb_seg_q  <= s1_seg_q;
      wb_best_q <= {cnt_new, s1_cls_x[CLS_W-1:0]};
    end
    if (out_load) begin
      out_q.no_data        <= lab_nd;
      out_q.majority_class <= lab_nd ? '0 : best_cls_x[CLASS_ID_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/smcv_checker.sv @@
// Checker: port-level assertions for the vote unit, and its bind.
module smcv_checker
  import smcv_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == CMD_CLEAR) |=> in_stall_o)
    else $error("item taken right after a clear");

  a_result_from_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc && (in_data_i.cmd == CMD_LABEL), 2))
    else $error("result without a label item");

  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_data |-> (out_data_o.majority_class == '0))
    else $error("no-data result carries a class");

endmodule

bind segment_majority_class_vote_unit smcv_checker u_smcv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/segment_majority_class_vote_checker.sv @@
// Checker for the segment vote unit: mirrors the vote stores, predicts label results, compares.
module segment_majority_class_vote_checker
  import smcv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_t              out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output int                error_count_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SEGMENTS_DEF * CLASSES_DEF;

  typedef logic [COUNT_BITS_DEF-1:0] count_t;

  count_t                pair_tally [SLOTS];
  count_t                lead_tally [SEGMENTS_DEF];
  logic [CLASS_ID_W-1:0] lead_class [SEGMENTS_DEF];

  logic                  seg_skip_en;
  logic [SEG_ID_W-1:0]   seg_skip;
  logic                  cls_skip_en;
  logic [CLASS_ID_W-1:0] cls_skip;

  out_t majority_q[$];
  int   errors;
  int   checked;

  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    errors++;
  endtask

  task automatic wipe_votes();
    for (int i = 0; i < SLOTS; i++) pair_tally[i] = '0;
    for (int s = 0; s < SEGMENTS_DEF; s++) begin
      lead_tally[s] = '0;
      lead_class[s] = '0;
    end
  endtask

  task automatic tally_pixel(input logic [SEG_ID_W-1:0] seg, input logic [CLASS_ID_W-1:0] cls);
    int     slot;
    count_t c;
    if (seg_skip_en && seg == seg_skip) return;
    if (cls_skip_en && cls == cls_skip) return;
    if (int'(seg) >= SEGMENTS_DEF || int'(cls) >= CLASSES_DEF) return;
    slot = int'(seg) * CLASSES_DEF + int'(cls);
    c = pair_tally[slot];
    if (c != '1) c = c + 1'b1;
    pair_tally[slot] = c;
    // ties keep the lowest class id
    if (c > lead_tally[seg] || (c == lead_tally[seg] && cls < lead_class[seg])) begin
      lead_tally[seg] = c;
      lead_class[seg] = cls;
    end
  endtask

  function automatic out_t majority_of(input logic [SEG_ID_W-1:0] seg);
    out_t r;
    r = '0;
    if ((seg_skip_en && seg == seg_skip) || int'(seg) >= SEGMENTS_DEF || lead_tally[seg] == '0) begin
      r.no_data = 1'b1;
    end else begin
      r.majority_class = lead_class[seg];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      wipe_votes();
      seg_skip_en = 1'b0;
      seg_skip    = '0;
      cls_skip_en = 1'b0;
      cls_skip    = '0;
      majority_q.delete();
      errors  = 0;
      checked = 0;
      error_count_o <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (majority_q.size() == 0) begin
          report_mismatch($sformatf("result class %0d no_data %0b with none expected",
                                    out_data_i.majority_class, out_data_i.no_data));
        end else begin
          want = majority_q.pop_front();
          checked++;
          if (out_data_i.majority_class !== want.majority_class ||
              out_data_i.no_data !== want.no_data) begin
            report_mismatch($sformatf("class %0d no_data %0b, expected class %0d no_data %0b",
                                      out_data_i.majority_class, out_data_i.no_data,
                                      want.majority_class, want.no_data));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.cmd)
          CMD_ACC:   tally_pixel(in_data_i.segment_id, in_data_i.class_id);
          CMD_LABEL: majority_q.push_back(majority_of(in_data_i.segment_id));
          CMD_CLEAR: wipe_votes();
          default: ;
        endcase
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_SEG_ND_EN:  seg_skip_en = pwdata_i[0];
          REG_SEG_ND_VAL: seg_skip    = pwdata_i[SEG_ID_W-1:0];
          REG_CLS_ND_EN:  cls_skip_en = pwdata_i[0];
          REG_CLS_ND_VAL: cls_skip    = pwdata_i[CLASS_ID_W-1:0];
          default: ;
        endcase
      end
      error_count_o <= errors;
      pending_o     <= majority_q.size();
      checked_o     <= checked;
    end
  end

endmodule

@@ test/segment_majority_class_vote_unit_test.sv @@
// Testbench top for the segment vote unit: clock, reset, item and register stimulus, verdict.
module segment_majority_class_vote_unit_test
  import smcv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_t              out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int sent_by_cmd [4];

  segment_majority_class_vote_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  segment_majority_class_vote_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .error_count_o (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_t pix(input logic [CMD_W-1:0] c, input int seg, input int cls);
    in_t px;
    px.cmd        = c;
    px.segment_id = SEG_ID_W'(seg);
    px.class_id   = CLASS_ID_W'(cls);
    return px;
  endfunction

  // mostly a small window of segments and classes so counts climb and tie
  function automatic in_t random_pixel(input int hot);
    in_t px;
    int  r;
    r = $urandom_range(99);
    px.cmd = (r < 58) ? CMD_ACC : (r < 94) ? CMD_LABEL : CMD_NONE;
    px.segment_id = ($urandom_range(99) < 80) ? SEG_ID_W'(hot + $urandom_range(7))
                                              : SEG_ID_W'($urandom);
    px.class_id = ($urandom_range(99) < 75) ? CLASS_ID_W'($urandom_range(3))
                                            : CLASS_ID_W'($urandom);
    return px;
  endfunction

  task automatic send_pixel(input in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    sent_by_cmd[px.cmd]++;
  endtask

  // drop valid, wait for all results, then for any clear sweep to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_skips(input logic seg_en, input int seg_val,
                           input logic cls_en, input int cls_val);
    write_reg(REG_SEG_ND_EN, DATA_W'(seg_en));
    write_reg(REG_SEG_ND_VAL, DATA_W'(seg_val));
    write_reg(REG_CLS_ND_EN, DATA_W'(cls_en));
    write_reg(REG_CLS_ND_VAL, DATA_W'(cls_val));
  endtask

  initial begin
    int hot;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // never counted, single votes, extremes, tie to lowest class, unused command, clear
    send_pixel(pix(CMD_LABEL, 0, 0));
    send_pixel(pix(CMD_ACC, 0, 0));
    send_pixel(pix(CMD_LABEL, 0, 0));
    send_pixel(pix(CMD_ACC, 1023, 15));
    send_pixel(pix(CMD_LABEL, 1023, 0));
    send_pixel(pix(CMD_ACC, 5, 9));
    send_pixel(pix(CMD_ACC, 5, 3));
    send_pixel(pix(CMD_LABEL, 5, 0));
    send_pixel(pix(CMD_ACC, 5, 9));
    send_pixel(pix(CMD_LABEL, 5, 0));
    send_pixel(pix(CMD_NONE, 5, 0));
    send_pixel(pix(CMD_LABEL, 5, 0));
    send_pixel(pix(CMD_CLEAR, 0, 0));
    send_pixel(pix(CMD_LABEL, 5, 0));
    send_pixel(pix(CMD_LABEL, 1023, 0));
    settle();

    // no-data skips at the low extremes
    set_skips(1'b1, 0, 1'b1, 0);
    send_pixel(pix(CMD_ACC, 0, 5));
    send_pixel(pix(CMD_LABEL, 0, 0));
    send_pixel(pix(CMD_ACC, 8, 0));
    send_pixel(pix(CMD_LABEL, 8, 0));
    send_pixel(pix(CMD_ACC, 8, 4));
    send_pixel(pix(CMD_LABEL, 8, 0));
    send_pixel(pix(CMD_ACC, 1023, 15));
    send_pixel(pix(CMD_LABEL, 1023, 0));

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: begin
          hot = $urandom_range(1008);
          set_skips(1'b1, hot + 2, 1'b1, 3);
          send_idle_pct  = 27;
          recv_stall_pct = 68;
        end
        1: begin
          hot = 1016;
          set_skips(1'b1, 1023, 1'b1, 15);
          send_idle_pct  = 68;
          recv_stall_pct = 27;
        end
        default: begin
          hot = $urandom_range(1016);
          set_skips(1'b0, 512, 1'b0, 8);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      send_pixel(pix(CMD_CLEAR, hot, 0));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) settle();
        send_pixel(random_pixel(hot));
      end
    end
    settle();

    $display("Sent %0d accumulate, %0d label, %0d clear, %0d unused-command items",
             sent_by_cmd[CMD_ACC], sent_by_cmd[CMD_LABEL], sent_by_cmd[CMD_CLEAR],
             sent_by_cmd[CMD_NONE]);
    $display("%0d label results compared over four skip settings and three stall mixes",
             checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/smcv_pkg.sv
src/segment_majority_class_vote_unit.sv
src/smcv_checker.sv
test/segment_majority_class_vote_checker.sv
test/segment_majority_class_vote_unit_test.sv
